// ===== design/modular_exponentiation_core_assert.svh =====
// assertion macros for the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define MEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mec_pkg.sv =====
// shared constants and types for the modular exponentiation core
package mec_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH);
    localparam int IDX_W      = 1;
    localparam logic [IDX_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [IDX_W-1:0] REG_EXPONENT = 1'b1;

    typedef logic [WORD_WIDTH-1:0] t_word;

    // handshake between the sequencer and the cell chain
    typedef struct packed {
        logic load;
        logic run;
    } t_mul_ctrl;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;
endpackage

// ===== design/mec_cell.sv =====
// one bit cell of the modular multiplier: holds an accumulator bit and its add/subtract slice
module mec_cell
    import mec_pkg::*;
(
    input  logic i_clk,
    input  logic i_clr,
    input  logic i_en,
    input  logic i_sel_diff,
    input  logic i_add,
    input  logic i_mod,
    input  logic i_carry,
    input  logic i_borrow,
    output logic o_acc,
    output logic o_carry,
    output logic o_borrow
);
    logic r_acc, n_acc;
    logic sum, diff;

    // add then subtract modulus, bit slice
    assign sum      = r_acc ^ i_add ^ i_carry;
    assign o_carry  = (r_acc & i_add) | (i_carry & (r_acc ^ i_add));
    assign diff     = sum ^ i_mod ^ i_borrow;
    assign o_borrow = (~sum & i_mod) | (i_borrow & ~(sum ^ i_mod));

    // keep the difference when the whole row says the sum reached the modulus
    assign n_acc = i_sel_diff ? diff : sum;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= 1'b0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== design/mec_mulmod.sv =====
// shift-and-add modular multiplier built as a row of bit cells, a doubling and an add phase for each bit
module mec_mulmod
    import mec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mul_ctrl i_ctrl,
    input  t_word     i_a,
    input  t_word     i_b,
    input  t_word     i_n,
    output logic      o_done,
    output t_word     o_p
);
    logic [WORD_WIDTH:0] acc_v;
    t_word r_b, r_a;
    logic [CNT_W-1:0] r_cnt;
    logic r_phase, r_busy;
    logic cell_en, sel_diff;

    // phase 0 doubles, phase 1 adds a when the bit of b is set
    logic [WORD_WIDTH:0] add_v;
    logic [WORD_WIDTH+1:0] carry;
    logic [WORD_WIDTH+1:0] borrow;
    logic [WORD_WIDTH:0] mod_x;

    assign add_v = r_phase ? (r_b[WORD_WIDTH-1] ? {1'b0, r_a} : '0) : acc_v;
    assign mod_x = {1'b0, i_n};
    assign carry[0] = 1'b0;
    assign borrow[0] = 1'b0;
    assign cell_en = r_busy && i_ctrl.run;

    // keep the difference when the sum reached the modulus
    assign sel_diff = carry[WORD_WIDTH+1] || !borrow[WORD_WIDTH+1];

    genvar g;
    generate
        for (g = 0; g <= WORD_WIDTH; g++) begin : g_cell
            mec_cell u_cell (
                .i_clk(i_clk), .i_clr(i_ctrl.load), .i_en(cell_en),
                .i_sel_diff(sel_diff), .i_add(add_v[g]), .i_mod(mod_x[g]),
                .i_carry(carry[g]), .i_borrow(borrow[g]),
                .o_acc(acc_v[g]), .o_carry(carry[g+1]), .o_borrow(borrow[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctrl.load) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy && i_ctrl.run) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(WORD_WIDTH - 1)) begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (cell_en) begin
            if (r_phase) r_b <= {r_b[WORD_WIDTH-2:0], 1'b0};
        end
    end

    assign o_p = acc_v[WORD_WIDTH-1:0];
endmodule

// ===== design/mec_reduce.sv =====
// bit-serial reduction of the message modulo the modulus, one bit a cycle
module mec_reduce
    import mec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_word i_x,
    input  t_word i_n,
    output logic  o_done,
    output t_word o_r
);
    logic [WORD_WIDTH:0] r_rem;
    t_word r_x;
    logic [CNT_W-1:0] r_cnt;
    logic r_busy;
    logic [WORD_WIDTH:0] sh;
    logic [WORD_WIDTH+1:0] dif;

    // restoring step: shift in the next bit, subtract when it fits
    assign sh  = {r_rem[WORD_WIDTH-1:0], r_x[WORD_WIDTH-1]};
    assign dif = {1'b0, sh} - {2'b00, i_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_x   <= i_x;
        end else if (r_busy) begin
            r_rem <= dif[WORD_WIDTH+1] ? sh : dif[WORD_WIDTH:0];
            r_x   <= {r_x[WORD_WIDTH-2:0], 1'b0};
        end
    end

    assign o_r = r_rem[WORD_WIDTH-1:0];
endmodule

// ===== design/modular_exponentiation_core.sv =====
// modular exponentiation core: message to the exponent, modulo the modulus
// sequence: reduce the message, then per exponent bit a square and, for a set bit, a multiply
// exponent zero runs only the squares, all ones adds a multiply after every square
// one message at a time; busy stays high until the result strobe cycle
// reset: synchronous active low, modulus 2, exponent 1, core idle
// the result strobe lasts one cycle and cannot be held off
module modular_exponentiation_core
    import mec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_word            i_message,
    output logic             o_valid,
    output t_word            o_result,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  t_word            i_cfg_data
);
`include "modular_exponentiation_core_assert.svh"

    t_word r_modulus, r_exponent, r_base, r_acc, r_exp;
    logic [CNT_W-1:0] r_bit;
    t_state r_state;
    logic r_wait;
    t_mul_ctrl mctrl;
    logic red_load, red_done, mul_done;
    t_word red_r, mul_p, mul_b;
    logic small_mod;

    assign small_mod = (r_modulus[WORD_WIDTH-1:1] == '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= t_word'(2);
            r_exponent <= t_word'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                REG_EXPONENT: r_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign red_load = start && !busy;
    assign mul_b = (r_state == ST_MULT) ? r_base : r_acc;

    // sequencer over the exponent bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            o_valid <= 1'b0;
            r_bit   <= '0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (red_load) r_state <= ST_REDUCE;
                ST_REDUCE: if (red_done) begin
                    r_state <= ST_SQUARE;
                    r_wait  <= 1'b0;
                    r_bit   <= '0;
                end
                ST_SQUARE: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (r_exp[WORD_WIDTH-1]) r_state <= ST_MULT;
                        else if (r_bit == CNT_W'(WORD_WIDTH - 1)) r_state <= ST_DONE;
                        else r_bit <= r_bit + 1'b1;
                    end
                end
                ST_MULT: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (r_bit == CNT_W'(WORD_WIDTH - 1)) r_state <= ST_DONE;
                        else begin
                            r_bit   <= r_bit + 1'b1;
                            r_state <= ST_SQUARE;
                        end
                    end
                end
                ST_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (red_load) r_exp <= r_exponent;
        if (r_state == ST_REDUCE && red_done) begin
            r_base <= red_r;
            r_acc  <= t_word'(1);
        end
        if (r_state == ST_SQUARE && r_wait && mul_done) begin
            r_acc <= mul_p;
            if (!r_exp[WORD_WIDTH-1]) r_exp <= {r_exp[WORD_WIDTH-2:0], 1'b0};
        end
        if (r_state == ST_MULT && r_wait && mul_done) begin
            r_acc <= mul_p;
            r_exp <= {r_exp[WORD_WIDTH-2:0], 1'b0};
        end
        if (r_state == ST_DONE) o_result <= small_mod ? '0 : r_acc;
    end

    assign mctrl.load = (r_state == ST_SQUARE || r_state == ST_MULT) && !r_wait;
    assign mctrl.run  = r_wait;

    mec_reduce u_reduce (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(red_load), .i_x(i_message),
        .i_n(r_modulus), .o_done(red_done), .o_r(red_r)
    );

    mec_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(mctrl), .i_a(r_acc), .i_b(mul_b),
        .i_n(r_modulus), .o_done(mul_done), .o_p(mul_p)
    );

    `MEC_ASSERT_IMP(a_no_start_when_busy, i_clk, i_rst_n, o_valid, r_state == ST_IDLE)
    `MEC_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == ST_DONE, o_valid)
    `MEC_ASSERT_IMP(a_mul_idle_wait, i_clk, i_rst_n, mul_done, r_wait)
endmodule
